[src/assert_macros.svh]
// Assertion macros used by the checker file of the list buffer.
// No dependencies; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define PLB_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list buffer check failed");

// Next-cycle implication, disabled while reset is high
`define PLB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list buffer check failed");

// Next-cycle implication that also holds across reset
`define PLB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("list buffer check failed");

`endif

[src/plb_pkg.sv]
// Types and codes for the positional list buffer.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none

package plb_pkg;

   localparam int ITEM_W = 32;
   localparam int POS_W  = 4;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   // Request codes
   typedef enum logic [OP_W-1:0] {
      OP_INS_HEAD = 3'd0,
      OP_INS_TAIL = 3'd1,
      OP_INS_POS  = 3'd2,
      OP_RM_HEAD  = 3'd3,
      OP_RM_TAIL  = 3'd4,
      OP_RM_POS   = 3'd5,
      OP_READ     = 3'd6,
      OP_CLEAR    = 3'd7
   } op_type;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Per-cycle command broadcast along the row of cells
   typedef struct packed {
      logic              ins_en;
      logic              rem_en;
      logic [ITEM_W-1:0] item;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/plb_if.sv]
// Request and response channel interfaces of the positional list buffer.
// Depends on plb_pkg for field widths.
`default_nettype none

interface plb_req_if;
   logic                              valid;
   logic                              ready;
   logic        [plb_pkg::OP_W-1:0]   op;
   logic        [plb_pkg::POS_W-1:0]  pos;
   logic signed [plb_pkg::ITEM_W-1:0] item;

   modport source (output valid, op, pos, item, input ready);
   modport sink   (input valid, op, pos, item, output ready);
endinterface

interface plb_rsp_if #(
   parameter int LEN_W = 5
);
   logic                              valid;
   logic                              ready;
   logic signed [plb_pkg::ITEM_W-1:0] read_item;
   logic        [plb_pkg::STAT_W-1:0] status;
   logic        [LEN_W-1:0]           length;

   modport source (output valid, read_item, status, length, input ready);
   modport sink   (input valid, read_item, status, length, output ready);
endinterface

`default_nettype wire

[src/plb_cell.sv]
// One storage cell of the list row: holds one item and shifts toward the
// tail on insert or toward the head on remove. Depends on plb_pkg.
`default_nettype none

module plb_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  wire                          clock,
   input  plb_pkg::cell_ctl_type        ctl,
   input  wire  [IDX_W-1:0]             p,
   input  wire  [plb_pkg::ITEM_W-1:0]   left_value,
   input  wire  [plb_pkg::ITEM_W-1:0]   right_value,
   output logic [plb_pkg::ITEM_W-1:0]   value
);
   import plb_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [ITEM_W-1:0] value_ff;
   logic [ITEM_W-1:0] value_in;

   // Insert: cells past the point take their head-side neighbour, the point
   // takes the new item. Remove: cells from the point on take the tail side.
   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (MY_IDX > p) begin
            value_in = left_value;
         end else if (MY_IDX == p) begin
            value_in = ctl.item;
         end
      end else if (ctl.rem_en) begin
         if (MY_IDX >= p) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

[src/positional_list_buffer.sv]
// Top level of the positional list buffer: request decode, the row of cells
// and the registered response. Depends on plb_pkg, plb_if and plb_cell.
`default_nettype none

// A bounded ordered list of up to CAPACITY signed 32-bit items, position 0
// at the head. Each request beat (insert head/tail/position, remove
// head/tail/position, read, clear) is handled in the cycle it is accepted:
// a successful insert or remove shifts the cells by one place in that cycle
// and the response beat (item, status, new length) appears from an output
// register in the next cycle. Requests are taken one per cycle whenever the
// response register is empty or being drained, so sustained throughput is
// one request per clock, as the cell row updates in the accept cycle. Reset
// clears only the length and the response valid flag, not the storage cells.
module positional_list_buffer #(
   parameter int CAPACITY = 16
) (
   input  wire        clock,
   input  wire        reset,
   plb_req_if.sink    req_chan,
   plb_rsp_if.source  rsp_chan
);
   import plb_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic              rsp_valid_ff;
   logic [ITEM_W-1:0] rsp_item_ff;
   logic [ITEM_W-1:0] rsp_item_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [CNT_W-1:0]  rsp_length_ff;

   logic              req_fire;
   op_type            op;
   logic [PW-1:0]     pos_x;
   logic [PW-1:0]     count_x;
   logic [PW-1:0]     p_x;
   logic [IDX_W-1:0]  p_idx;
   cell_ctl_type      ctl;

   logic [ITEM_W-1:0] cell_q [CAPACITY];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign op             = op_type'(req_chan.op);
   assign pos_x          = PW'(req_chan.pos);
   assign count_x        = PW'(count_ff);
   assign p_idx          = p_x[IDX_W-1:0];

   // Request decode: target position, status, new length, cell command
   always_comb begin
      p_x           = pos_x;
      count_in      = count_ff;
      rsp_item_in   = '0;
      rsp_status_in = ST_OK;
      ctl.ins_en    = 1'b0;
      ctl.rem_en    = 1'b0;
      ctl.item      = req_chan.item;
      case (op)
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
            if (op == OP_INS_HEAD) begin
               p_x = '0;
            end else if (op == OP_INS_TAIL) begin
               p_x = count_x;
            end
            if (count_ff == CAP_CNT) begin
               rsp_status_in = ST_FULL;
            end else if (p_x > count_x) begin
               rsp_status_in = ST_RANGE;
            end else begin
               ctl.ins_en = req_fire;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         OP_RM_HEAD, OP_RM_TAIL, OP_RM_POS, OP_READ: begin
            if (op == OP_RM_HEAD) begin
               p_x = '0;
            end else if (op == OP_RM_TAIL) begin
               p_x = count_x - PW'(1);
            end
            if (count_ff == '0) begin
               rsp_status_in = ST_EMPTY;
            end else if (p_x >= count_x) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_item_in = cell_q[p_idx];
               if (op != OP_READ) begin
                  ctl.rem_en = req_fire;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Row of cells, each wired to its neighbours
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ITEM_W-1:0] left_v;
      logic [ITEM_W-1:0] right_v;
      if (gi == 0) begin : g_head
         assign left_v = req_chan.item;
      end else begin : g_mid
         assign left_v = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
         assign right_v = cell_q[gi];
      end else begin : g_body
         assign right_v = cell_q[gi+1];
      end
      plb_cell #(
         .IDX_W (IDX_W),
         .INDEX (gi)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .p           (p_idx),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_q[gi])
      );
   end

   // Length register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_fire) begin
         count_ff <= count_in;
      end
   end

   // Response register: loads on each accepted beat, drains on ready
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_item_ff   <= rsp_item_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= count_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_item = rsp_item_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.length    = rsp_length_ff;

endmodule

`default_nettype wire

[src/plb_checker.sv]
// Port-level checks for the positional list buffer, bound to the top level.
// Depends on plb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module plb_checker #(
   parameter int CAPACITY = 16,
   parameter int LEN_W    = 5
) (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire [plb_pkg::ITEM_W-1:0]    rsp_read_item,
   input wire [plb_pkg::STAT_W-1:0]    rsp_status,
   input wire [LEN_W-1:0]              rsp_length
);
   import plb_pkg::*;

   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   // No response beat straight after reset
   `PLB_ASSERT_NEXT_ALWAYS(a_rst_idle, clock, reset, !rsp_valid)

   // A failed request returns no data
   `PLB_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_read_item == '0)

   // Full status only when the list is at capacity; length never beyond it
   `PLB_ASSERT_SAME(a_full_len, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_length == CAP_LEN)
   `PLB_ASSERT_SAME(a_len_cap, clock, reset, rsp_valid, rsp_length <= CAP_LEN)

   // An accepted beat always yields a response beat next cycle
   `PLB_ASSERT_NEXT(a_rsp_follows, clock, reset, req_valid && req_ready, rsp_valid)

endmodule

bind positional_list_buffer plb_checker #(
   .CAPACITY (CAPACITY),
   .LEN_W    ($clog2(CAPACITY + 1))
) u_plb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_read_item (rsp_chan.read_item),
   .rsp_status    (rsp_chan.status),
   .rsp_length    (rsp_chan.length)
);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for the positional list buffer: directed script, then
// random list traffic with random stalls on both channels, checked beat by beat.
// Depends on plb_pkg, plb_if and positional_list_buffer.
`default_nettype none

module tb;
   import plb_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 950;
   localparam int LONG_HOLD = 80;      // receiver hold-off, in cycles
   localparam int HOLD_AT_BEAT = 300;  // response beat at which it starts
   localparam int DRAIN_CYCLES = 8;

   // Bias of the random op mix
   typedef enum int {
      TREND_FILL,
      TREND_DRAIN,
      TREND_MIXED
   } list_trend_type;

   typedef struct packed {
      logic signed [ITEM_W-1:0] read_item;
      status_type               status;
      logic [4:0]               length;
   } list_result_type;

   typedef struct {
      op_type                   op;
      logic [POS_W-1:0]         pos;
      logic signed [ITEM_W-1:0] item;
      int                       reps;
      bit                       typed;
      list_result_type          want;
   } script_row_type;

   logic clock;
   logic reset;

   plb_req_if             req_chan ();
   plb_rsp_if #(.LEN_W(5)) rsp_chan ();

   positional_list_buffer #(.CAPACITY(CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the list contents
   logic signed [ITEM_W-1:0] list_cells [CAPACITY];
   int                       list_len;

   list_result_type pending_rsp [$];
   script_row_type  script [$];
   int              errors;
   bit              send_gaps_on;
   bit              rsp_gaps_on;

   // Apply one request to the shadow list, return the response it should give
   function automatic list_result_type list_update(op_type op, logic [POS_W-1:0] pos,
                                                   logic signed [ITEM_W-1:0] item);
      list_result_type r;
      int              p;
      r.read_item = '0;
      r.status    = ST_OK;
      case (op)
         OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
            p = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? list_len : int'(pos);
            if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (p > list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (int i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
               list_cells[p] = item;
               list_len++;
            end
         end
         OP_RM_HEAD, OP_RM_TAIL, OP_RM_POS, OP_READ: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               p = (op == OP_RM_HEAD) ? 0 : (op == OP_RM_TAIL) ? list_len - 1 : int'(pos);
               if (p >= list_len) begin
                  r.status = ST_RANGE;
               end else if (op == OP_READ) begin
                  r.read_item = list_cells[p];
               end else begin
                  r.read_item = list_cells[p];
                  for (int i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                  list_len--;
               end
            end
         end
         default: begin
            list_len = 0;
         end
      endcase
      r.length = list_len[4:0];
      return r;
   endfunction

   // Draw an op with the mix leaning toward the current trend
   function automatic op_type pick_op(list_trend_type trend);
      int r;
      int ins_pct;
      int rm_pct;
      r       = $urandom_range(0, 99);
      ins_pct = (trend == TREND_FILL) ? 60 : (trend == TREND_DRAIN) ? 25 : 40;
      rm_pct  = (trend == TREND_FILL) ? 25 : (trend == TREND_DRAIN) ? 55 : 40;
      if (r < 2) return OP_CLEAR;
      if (r < 2 + ins_pct) return op_type'($urandom_range(OP_INS_HEAD, OP_INS_POS));
      if (r < 2 + ins_pct + rm_pct) return op_type'($urandom_range(OP_RM_HEAD, OP_RM_POS));
      return OP_READ;
   endfunction

   // Mostly a position the list can take, now and then any position
   function automatic logic [POS_W-1:0] pick_pos(op_type op);
      int top;
      if ($urandom_range(0, 99) < 12) return POS_W'($urandom_range(0, 15));
      if (op == OP_INS_POS) top = (list_len > 15) ? 15 : list_len;
      else top = (list_len == 0) ? 0 : list_len - 1;
      return POS_W'($urandom_range(0, top));
   endfunction

   task automatic plan(op_type op, int pos, logic signed [ITEM_W-1:0] item, int reps,
                       bit typed, logic signed [ITEM_W-1:0] rd, status_type st, int len);
      script_row_type row;
      row.op             = op;
      row.pos            = POS_W'(pos);
      row.item           = item;
      row.reps           = reps;
      row.typed          = typed;
      row.want.read_item = rd;
      row.want.status    = st;
      row.want.length    = 5'(len);
      script.push_back(row);
   endtask

   // Offer one request beat and wait until it is taken
   task automatic send_request(op_type op, logic [POS_W-1:0] pos,
                               logic signed [ITEM_W-1:0] item, bit typed,
                               list_result_type want);
      int              gap;
      list_result_type r;
      gap = send_gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.op    <= op;
      req_chan.pos   <= pos;
      req_chan.item  <= item;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      r = list_update(op, pos, item);
      pending_rsp.push_back(typed ? want : r);
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Overall time limit
   initial begin
      #2400000;
      $display("tb failed");
      $finish;
   end

   // Response side: random ready, one long hold-off to back the block up
   initial begin : rsp_side
      int beats;
      int hold;
      beats       = 0;
      rsp_gaps_on = 1'b1;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (beats % 64 == 0) rsp_gaps_on = ($urandom_range(0, 3) != 0);
         if (beats == HOLD_AT_BEAT) hold = LONG_HOLD;
         else hold = rsp_gaps_on ? $urandom_range(0, 4) : 0;
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         beats++;
      end
   end

   // Compare every response beat with the oldest pending expectation
   always @(posedge clock) begin : check_rsp
      list_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response beat with none pending: item %0d status %0d length %0d",
                     $time, rsp_chan.read_item, rsp_chan.status, rsp_chan.length);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_chan.read_item !== want.read_item) begin
               $display("%0t: read_item expected %0d, got %0d",
                        $time, want.read_item, rsp_chan.read_item);
               errors++;
            end
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_chan.status);
               errors++;
            end
            if (rsp_chan.length !== want.length) begin
               $display("%0t: length expected %0d, got %0d",
                        $time, want.length, rsp_chan.length);
               errors++;
            end
         end
      end
   end

   // Reset, directed script, random traffic, drain and verdict
   initial begin : stimulus
      list_result_type  none;
      script_row_type   row;
      op_type           op;
      logic [POS_W-1:0] pos;
      list_trend_type   trend;
      errors       = 0;
      list_len     = 0;
      send_gaps_on = 1'b1;
      none         = '0;
      trend        = TREND_FILL;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.op    <= OP_INS_HEAD;
      req_chan.pos   <= '0;
      req_chan.item  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Empty list: removes and reads report empty, even with a bad position; an insert past the end is out of range
      plan(OP_RM_HEAD,  0, 0, 1, 1, 0, ST_EMPTY, 0);
      plan(OP_RM_POS,  15, 0, 1, 1, 0, ST_EMPTY, 0);
      plan(OP_READ,     0, 0, 1, 1, 0, ST_EMPTY, 0);
      plan(OP_INS_POS,  1, 5, 1, 1, 0, ST_RANGE, 0);
      // Extreme values, append by position, insert in the middle
      plan(OP_INS_HEAD, 0, 32'h7FFF_FFFF, 1, 1, 0, ST_OK, 1);
      plan(OP_INS_TAIL, 0, 32'h8000_0000, 1, 1, 0, ST_OK, 2);
      plan(OP_INS_POS,  2, -1, 1, 0, 0, ST_OK, 0);
      plan(OP_INS_POS,  1,  0, 1, 0, 0, ST_OK, 0);
      plan(OP_READ,     0,  0, 1, 1, 32'h7FFF_FFFF, ST_OK, 4);
      // Positions just past the end
      plan(OP_READ,     4, 0, 1, 1, 0, ST_RANGE, 4);
      plan(OP_RM_POS,   4, 0, 1, 1, 0, ST_RANGE, 4);
      plan(OP_INS_POS,  5, 0, 1, 1, 0, ST_RANGE, 4);
      plan(OP_RM_POS,   1, 0, 1, 0, 0, ST_OK, 0);
      plan(OP_RM_TAIL,  0, 0, 1, 0, 0, ST_OK, 0);
      plan(OP_CLEAR,    0, 0, 1, 1, 0, ST_OK, 0);
      // Fill to capacity, then every insert is refused as full
      plan(OP_INS_TAIL, 0, 32'h5A5A_0000, CAPACITY, 0, 0, ST_OK, 0);
      plan(OP_INS_HEAD, 0, 1, 1, 1, 0, ST_FULL, 16);
      plan(OP_INS_POS, 15, 2, 1, 1, 0, ST_FULL, 16);
      plan(OP_INS_TAIL, 0, 3, 1, 1, 0, ST_FULL, 16);
      plan(OP_READ,    15, 0, 1, 1, 32'h5A5A_000F, ST_OK, 16);
      plan(OP_RM_POS,  15, 0, 1, 0, 0, ST_OK, 0);
      plan(OP_RM_POS,   0, 0, 1, 0, 0, ST_OK, 0);
      plan(OP_INS_POS, 15, 4, 1, 1, 0, ST_RANGE, 14);
      plan(OP_CLEAR,    0, 0, 1, 1, 0, ST_OK, 0);

      foreach (script[i]) begin
         row = script[i];
         for (int k = 0; k < row.reps; k++)
            send_request(row.op, row.pos, row.item + k, row.typed, row.want);
      end

      // Random traffic in stretches that lean toward filling, draining or a mix
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) trend = list_trend_type'($urandom_range(0, 2));
         if (n % 64 == 0) send_gaps_on = ($urandom_range(0, 3) != 0);
         op  = pick_op(trend);
         pos = pick_pos(op);
         send_request(op, pos, $urandom, 1'b0, none);
      end
      req_chan.valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/plb_pkg.sv
src/plb_if.sv
src/plb_cell.sv
src/positional_list_buffer.sv
src/plb_checker.sv
tb/sv/tb.sv
